@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, reset masks the check.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/cfe_pkg.sv @@
// Shared types and constants of the COBS frame encoder.
package cfe_pkg;

  localparam logic [7:0] DELIM_BYTE = 8'h00;

  // Output byte source select
  localparam logic [1:0] SEL_DELIM = 2'd0;
  localparam logic [1:0] SEL_CODE  = 2'd1;
  localparam logic [1:0] SEL_DATA  = 2'd2;

  typedef struct packed {
    logic       take;       // input beat accepted this cycle
    logic       emit;       // load output register
    logic [1:0] sel;        // output byte source
    logic       run_last;   // last beat of this item
    logic       adv;        // step block read pointer
    logic       close_blk;  // block fully sent
  } cfe_cmd_t;

  typedef struct packed {
    logic at_start;   // incoming byte opens a frame
    logic in_zero;    // incoming byte is zero
    logic in_last;    // incoming byte ends the frame (flag or length limit)
    logic pend_zero;  // zero-byte block close pending
    logic pend_last;  // end-of-frame block close pending
    logic blk_empty;  // open block holds no bytes
    logic data_end;   // read pointer at last stored byte
    logic out_ready;  // output register can take a beat
  } cfe_status_t;

endpackage

@@ hdl/cfe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/cfe_dpath.sv @@
// Datapath: frame/block counters, block store, output register.
module cfe_dpath #(
  parameter int MAX_FRAME = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_end_i,
  input  cfe_pkg::cfe_cmd_t    cmd_i,
  output cfe_pkg::cfe_status_t status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          coded_byte_o,
  output logic                run_last_o
);
  import cfe_pkg::*;

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

  logic [CW-1:0] block_cnt_q, block_cnt_d;
  logic [CW-1:0] frame_cnt_q, frame_cnt_d;
  logic [CW-1:0] frame_inc;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic          at_start_q, at_start_d;
  logic          pend_zero_q, pend_zero_d;
  logic          pend_last_q, pend_last_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    coded_byte_q;
  logic          run_last_q;
  logic [7:0]    emit_byte;
  logic [7:0]    rd_data;
  logic          in_zero, in_last, store_we;

  assign in_zero   = (data_byte_i == 8'h00);
  assign frame_inc = frame_cnt_q + CW'(1);
  // length limit forces the frame to close
  assign in_last   = frame_end_i | (frame_inc == CW'(MAX_FRAME));
  assign store_we  = cmd_i.take & ~in_zero & (block_cnt_q < CW'(MAX_FRAME));

  // read address is the next pointer value so the registered data lines up
  cfe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (block_cnt_q[AW-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (rd_ptr_d),
    .rdata_o (rd_data)
  );

  always_comb begin
    block_cnt_d = block_cnt_q;
    frame_cnt_d = frame_cnt_q;
    rd_ptr_d    = rd_ptr_q;
    at_start_d  = at_start_q;
    pend_zero_d = pend_zero_q;
    pend_last_d = pend_last_q;
    if (cmd_i.take) begin
      at_start_d  = in_last;
      frame_cnt_d = in_last ? '0 : frame_inc;
      pend_zero_d = in_zero;
      pend_last_d = in_last;
      if (store_we) begin
        block_cnt_d = block_cnt_q + CW'(1);
      end
    end
    if (cmd_i.adv) begin
      rd_ptr_d = rd_ptr_q + AW'(1);
    end
    if (cmd_i.close_blk) begin
      block_cnt_d = '0;
      rd_ptr_d    = '0;
      // zero-byte close always precedes the end-of-frame close
      if (pend_zero_q) begin
        pend_zero_d = 1'b0;
      end else begin
        pend_last_d = 1'b0;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.sel)
      SEL_DELIM: emit_byte = DELIM_BYTE;
      SEL_CODE:  emit_byte = 8'(block_cnt_q) + 8'd1;
      SEL_DATA:  emit_byte = rd_data;
      default:   emit_byte = DELIM_BYTE;
    endcase
  end

  assign out_valid_d = cmd_i.emit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_cnt_q <= '0;
      frame_cnt_q <= '0;
      rd_ptr_q    <= '0;
      at_start_q  <= 1'b1;
      pend_zero_q <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      block_cnt_q <= block_cnt_d;
      frame_cnt_q <= frame_cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      at_start_q  <= at_start_d;
      pend_zero_q <= pend_zero_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      coded_byte_q <= emit_byte;
      run_last_q   <= cmd_i.run_last;
    end
  end

  assign status_o.at_start  = at_start_q;
  assign status_o.in_zero   = in_zero;
  assign status_o.in_last   = in_last;
  assign status_o.pend_zero = pend_zero_q;
  assign status_o.pend_last = pend_last_q;
  assign status_o.blk_empty = (block_cnt_q == '0);
  assign status_o.data_end  = ((CW'(rd_ptr_q) + CW'(1)) == block_cnt_q);
  assign status_o.out_ready = ~out_valid_q | ~out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign coded_byte_o = coded_byte_q;
  assign run_last_o   = run_last_q;

endmodule

@@ hdl/cfe_ctrl.sv @@
// Controller: sequences delimiter, block code and block data beats.
module cfe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cfe_pkg::cfe_status_t status_i,
  output cfe_pkg::cfe_cmd_t    cmd_o
);
  import cfe_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HEAD = 3'd1;
  localparam logic [2:0] ST_CODE = 3'd2;
  localparam logic [2:0] ST_DATA = 3'd3;
  localparam logic [2:0] ST_TAIL = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] after_blk;
  logic       blk_run_last;

  // where to go once the current block has been sent
  assign after_blk    = status_i.pend_zero ? (status_i.pend_last ? ST_CODE : ST_IDLE)
                                           : ST_TAIL;
  assign blk_run_last = status_i.pend_zero & ~status_i.pend_last;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = SEL_DELIM;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.at_start) begin
            state_d = ST_HEAD;
          end else if (status_i.in_zero || status_i.in_last) begin
            state_d = ST_CODE;
          end
        end
      end
      ST_HEAD: begin
        if (status_i.out_ready) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = SEL_DELIM;
          cmd_o.run_last = ~status_i.pend_zero & ~status_i.pend_last;
          state_d = (status_i.pend_zero || status_i.pend_last) ? ST_CODE : ST_IDLE;
        end
      end
      ST_CODE: begin
        if (status_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_CODE;
          if (status_i.blk_empty) begin
            cmd_o.close_blk = 1'b1;
            cmd_o.run_last  = blk_run_last;
            state_d = after_blk;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (status_i.out_ready) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_DATA;
          if (status_i.data_end) begin
            cmd_o.close_blk = 1'b1;
            cmd_o.run_last  = blk_run_last;
            state_d = after_blk;
          end else begin
            cmd_o.adv = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        if (status_i.out_ready) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = SEL_DELIM;
          cmd_o.run_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/cobs_frame_encoder_unit.sv @@
// COBS frame encoder top level: controller plus datapath.
//
// Input channel: one raw frame byte per beat (data_byte_i), frame_end_i on the
// final byte. A frame is cut after MAX_FRAME bytes even without frame_end_i.
// Output channel: encoded bytes (coded_byte_o), run_last_o marks the final
// output beat caused by an input beat. Zero input bytes are not sent.
// Frame layout: 0x00, then per block a length code and its nonzero bytes,
// then a trailing 0x00.
// Throughput: a nonzero byte inside a frame is taken without raising
// in_stall_o. A byte that causes output beats holds in_stall_o high while
// the controller emits one beat per cycle, when the output is not stalled,
// from the block store (registered RAM read port, one read per cycle).
// First beat: an accepted item first moves the controller state register,
// which then loads the first output beat into the output register.
// Output stall: out_stall_i freezes a held output beat and the sequence;
// the input stalls until the last pending beat is in the output register.
// Reset: block and frame counts clear, next byte opens a new frame, no output
// beat is pending.
module cobs_frame_encoder_unit #(
  parameter int MAX_FRAME = 14
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] coded_byte_o,
  output logic       run_last_o
);
  import cfe_pkg::*;

  cfe_cmd_t    cmd;
  cfe_status_t status;

  cfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cfe_dpath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_byte_i  (data_byte_i),
    .frame_end_i  (frame_end_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .coded_byte_o (coded_byte_o),
    .run_last_o   (run_last_o)
  );

endmodule

@@ hdl/cfe_checker.sv @@
// Port-level checker for the COBS frame encoder, with its bind.
`include "assert_macros.svh"

module cfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] data_byte_i,
  input logic       frame_end_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] coded_byte_o,
  input logic       run_last_o
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid_i & ~in_stall_o;
  assign out_beat = out_valid_o & ~out_stall_i;

  // a closing byte always produces output, so the input must stall next
  `ASSERT_NEXT(a_end_busy, clk_i, rst_ni, in_beat && frame_end_i, in_stall_o)
  `ASSERT_NEXT(a_zero_busy, clk_i, rst_ni, in_beat && data_byte_i == 8'h00, in_stall_o)
  // a held beat keeps its payload
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(coded_byte_o) && $stable(run_last_o))
  // an accepted output beat that is not its item's last keeps the input stalled
  `ASSERT_IMPL(a_busy_out, clk_i, rst_ni, out_beat && !run_last_o, in_stall_o)

endmodule

bind cobs_frame_encoder_unit cfe_checker u_cfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .data_byte_i  (data_byte_i),
  .frame_end_i  (frame_end_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .coded_byte_o (coded_byte_o),
  .run_last_o   (run_last_o)
);

@@ dv/cobs_frame_encoder_unit_tb.sv @@
// Testbench for cobs_frame_encoder_unit: directed and random frames checked against a COBS predictor.
`timescale 1ns / 100ps

module cobs_frame_encoder_unit_tb;
  import cfe_pkg::*;

  localparam int MAX_FRAME  = 14;
  localparam int ITEM_GOAL  = 370;
  localparam int IDLE_PCT   = 11;
  localparam int HOLD_LEN   = 40;
  localparam int WDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_beat_t;

  typedef struct packed {
    logic [7:0] coded;
    logic       last;
  } coded_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       frame_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] coded_byte_o;
  logic       run_last_o;

  cobs_frame_encoder_unit #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .coded_byte_o(coded_byte_o),
    .run_last_o  (run_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Encoder shadow state
  logic [7:0]  blk_store [MAX_FRAME];
  logic [3:0]  blk_cnt;
  logic [3:0]  frame_cnt;
  logic        at_start;
  logic [7:0]  burst_q[$];
  coded_beat_t coded_q[$];

  raw_beat_t   raw_q[$];
  raw_beat_t   nxt_raw;
  coded_beat_t want;
  int          n_taken;
  int          n_errors;
  int          hold_left;
  bit          hold_done;
  int          idle_cycles;
  logic        calm;

  // no idling on either side for a stretch of the run
  assign calm = (n_taken >= 150) && (n_taken < 230);

  task automatic close_block();
    burst_q.push_back(8'(blk_cnt) + 8'd1);
    for (int k = 0; k < int'(blk_cnt); k++) burst_q.push_back(blk_store[k]);
    blk_cnt = '0;
  endtask

  task automatic encode_byte(input logic [7:0] raw, input logic frame_end);
    logic ends_frame;
    ends_frame = frame_end;
    burst_q.delete();
    if (at_start) begin
      burst_q.push_back(DELIM_BYTE);
      at_start = 1'b0;
    end
    if (frame_cnt < MAX_FRAME) frame_cnt++;
    // length saturation forces the frame to close
    if (frame_cnt >= MAX_FRAME) ends_frame = 1'b1;
    if (raw == 8'h00) begin
      close_block();
    end else if (blk_cnt < MAX_FRAME) begin
      blk_store[blk_cnt] = raw;
      blk_cnt++;
    end
    if (ends_frame) begin
      close_block();
      burst_q.push_back(DELIM_BYTE);
      frame_cnt = '0;
      at_start  = 1'b1;
    end
    foreach (burst_q[k]) coded_q.push_back('{burst_q[k], k == burst_q.size() - 1});
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
    n_errors++;
    if (n_errors <= 10)
      $display("[%0t] mismatch on %s: expected %02h, got %02h", $realtime, what, exp_v, got_v);
  endtask

  task automatic add_raw(input logic [7:0] data, input logic last);
    raw_q.push_back('{data, last});
  endtask

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= '0;
      frame_end_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        encode_byte(data_byte_i, frame_end_i);
        n_taken++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (raw_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt_raw = raw_q.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= nxt_raw.data;
          frame_end_i <= nxt_raw.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (coded_q.size() == 0) begin
          flag_mismatch("unexpected beat", 8'h00, coded_byte_o);
        end else begin
          want = coded_q.pop_front();
          if (coded_byte_o !== want.coded) flag_mismatch("coded_byte", want.coded, coded_byte_o);
          if (run_last_o !== want.last)
            flag_mismatch("run_last", 8'(want.last), 8'(run_last_o));
        end
      end
      // one long hold-off so the block backs up into the input
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!hold_done && n_taken >= 60) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_LEN - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int len;
    int kind;
    bit open_end;
    blk_cnt     = '0;
    frame_cnt   = '0;
    at_start    = 1'b1;
    n_taken     = 0;
    n_errors    = 0;
    idle_cycles = 0;
    rst_ni      = 1'b0;

    // directed frames
    add_raw(8'h01, 1'b1);                       // single nonzero byte
    add_raw(8'h00, 1'b1);                       // lone zero as final byte
    add_raw(8'hFF, 1'b0);
    add_raw(8'h80, 1'b0);
    add_raw(8'h00, 1'b0);
    add_raw(8'h7F, 1'b1);
    add_raw(8'h00, 1'b0);                       // zeros only
    add_raw(8'h00, 1'b1);
    for (int k = 0; k < MAX_FRAME; k++)         // cut by length, no end flag
      add_raw(8'(k * 17 + 3), 1'b0);

    // random frames: mostly short and well formed, some full or overrunning
    while (raw_q.size() < ITEM_GOAL) begin
      kind     = $urandom_range(9);
      open_end = 1'b0;
      if (kind == 0) begin
        len      = $urandom_range(MAX_FRAME + 1, MAX_FRAME + 6);
        open_end = 1'b1;
      end else if (kind == 1) begin
        len = MAX_FRAME;
      end else begin
        len = $urandom_range(1, 8);
      end
      for (int k = 0; k < len; k++)
        add_raw(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                !open_end && (k == len - 1));
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (raw_q.size() != 0 || in_valid_i || coded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (n_errors == 0 && coded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
